>>> rtl/tlrxh_pkg.sv
package tlrxh_pkg;

  // Number of entries in the prime table and the width of a table position.
  localparam int unsigned PrimeCount = 17;
  localparam int unsigned PosW       = 5;
  localparam int unsigned HashW      = 32;
  localparam int unsigned RotAmt     = 13;

  // Whitespace codes that are trimmed at both ends of a line.
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;

  // One request on the input channel.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_char;
    logic       end_of_line;
  } item_t;

  // Prime for a table position. A position past the table reads as the first entry.
  function automatic logic [HashW-1:0] prime_at(input logic [PosW-1:0] pos);
    logic [HashW-1:0] p;
    unique case (pos)
      5'd0:    p = 32'd43;
      5'd1:    p = 32'd101;
      5'd2:    p = 32'd149;
      5'd3:    p = 32'd193;
      5'd4:    p = 32'd241;
      5'd5:    p = 32'd293;
      5'd6:    p = 32'd353;
      5'd7:    p = 32'd409;
      5'd8:    p = 32'd461;
      5'd9:    p = 32'd521;
      5'd10:   p = 32'd587;
      5'd11:   p = 32'd641;
      5'd12:   p = 32'd691;
      5'd13:   p = 32'd757;
      5'd14:   p = 32'd823;
      5'd15:   p = 32'd881;
      5'd16:   p = 32'd947;
      default: p = 32'd43;
    endcase
    return p;
  endfunction

  // Space, tab and carriage return count as whitespace.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CharSpace) || (c == CharTab) || (c == CharCr);
  endfunction

  // Fixed left rotation of the running sum.
  function automatic logic [HashW-1:0] rotl(input logic [HashW-1:0] x);
    return {x[HashW-RotAmt-1:0], x[HashW-1:HashW-RotAmt]};
  endfunction

endpackage

>>> rtl/tlrxh_core.sv
module tlrxh_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  tlrxh_pkg::item_t              item_i,
  output logic [tlrxh_pkg::HashW-1:0]   hash_o
);

  logic [tlrxh_pkg::HashW-1:0] committed_q, committed_d;
  logic [tlrxh_pkg::HashW-1:0] tentative_q, tentative_d;
  logic [tlrxh_pkg::PosW-1:0]  pos_q, pos_d;
  logic                        seen_q, seen_d;

  logic                        white;
  logic                        seen_now;
  logic                        hashing;
  logic                        commit;
  logic [tlrxh_pkg::PosW-1:0]  pos_use;
  logic [tlrxh_pkg::PosW-1:0]  pos_inc;
  logic [tlrxh_pkg::HashW-1:0] tent_new;

  // Per-byte update: one table read, two XORs and a fixed rotate.
  always_comb begin
    white    = tlrxh_pkg::is_blank(item_i.char_byte);
    seen_now = seen_q | (item_i.has_char & ~white);
    hashing  = item_i.has_char & seen_now;
    commit   = hashing & ~white;
    pos_use  = (pos_q < tlrxh_pkg::PosW'(tlrxh_pkg::PrimeCount)) ? pos_q : '0;
    pos_inc  = pos_use + tlrxh_pkg::PosW'(1);
    tent_new = tlrxh_pkg::rotl(tentative_q ^ tlrxh_pkg::prime_at(pos_use)
                               ^ {{(tlrxh_pkg::HashW-8){1'b0}}, item_i.char_byte});
    hash_o   = commit ? tent_new : committed_q;
  end

  // Next state. The end of a line returns every sum to zero.
  always_comb begin
    committed_d = committed_q;
    tentative_d = tentative_q;
    pos_d       = pos_q;
    seen_d      = seen_q;
    if (adv_i) begin
      if (item_i.end_of_line) begin
        committed_d = '0;
        tentative_d = '0;
        pos_d       = '0;
        seen_d      = 1'b0;
      end else begin
        seen_d = seen_now;
        if (hashing) begin
          tentative_d = tent_new;
          pos_d = (pos_inc >= tlrxh_pkg::PosW'(tlrxh_pkg::PrimeCount)) ? '0 : pos_inc;
        end
        if (commit) begin
          committed_d = tent_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      committed_q <= '0;
      tentative_q <= '0;
      pos_q       <= '0;
      seen_q      <= 1'b0;
    end else begin
      committed_q <= committed_d;
      tentative_q <= tentative_d;
      pos_q       <= pos_d;
      seen_q      <= seen_d;
    end
  end

  // The table position always stays inside the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < tlrxh_pkg::PosW'(tlrxh_pkg::PrimeCount))
    else $error("prime position left the table");

  // Before the first non-white byte of a line nothing has been summed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> (committed_q == '0 && tentative_q == '0 && pos_q == '0))
    else $error("sum changed during leading whitespace");

  // A finished line leaves the state cleared for the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && item_i.end_of_line) |=> (!seen_q && committed_q == '0))
    else $error("state not cleared after line end");

  // After a non-white byte is committed, both sums agree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && commit && !item_i.end_of_line) |=> (committed_q == tentative_q))
    else $error("committed sum differs from tentative sum after a non-white byte");

endmodule

>>> rtl/trimmed_line_rotate_xor_hash.sv
// Hashes a text line that arrives one byte per request and returns one 32-bit
// result for each request with end_of_line set; other requests give no result.
// Leading and trailing space, tab and carriage return are left out of the hash,
// and an empty or all-white line hashes to zero. The block takes one request per
// cycle, also while a result waits, until a second line end meets a full output
// register. A request is held in an input register while the running sums are
// updated, and the hash waits in an output register; out_valid_o rises once the
// line end has moved from the input register into the output register, and the
// result can be taken at the following edge. The update of the running sums
// (table read, XORs, rotate) is combinational.
module trimmed_line_rotate_xor_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_byte_i,
  input  logic        has_char_i,
  input  logic        end_of_line_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] line_hash_o
);

  logic                        stg_valid_q;
  tlrxh_pkg::item_t            stg_item_q;
  logic                        stg_adv;
  logic                        out_valid_q;
  logic [tlrxh_pkg::HashW-1:0] out_hash_q;
  logic [tlrxh_pkg::HashW-1:0] hash;

  // The stage moves unless it holds a line end and the output is still full.
  assign stg_adv    = stg_valid_q & (~stg_item_q.end_of_line | ~out_valid_q | out_ready_i);
  assign in_ready_o = ~stg_valid_q | stg_adv;

  tlrxh_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (stg_adv),
    .item_i (stg_item_q),
    .hash_o (hash)
  );

  // Valid flags of the input and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        stg_valid_q <= in_valid_i;
      end
      if (stg_adv && stg_item_q.end_of_line) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      stg_item_q.char_byte   <= char_byte_i;
      stg_item_q.has_char    <= has_char_i;
      stg_item_q.end_of_line <= end_of_line_i;
    end
    if (stg_adv && stg_item_q.end_of_line) begin
      out_hash_q <= hash;
    end
  end

  assign out_valid_o = out_valid_q;
  assign line_hash_o = out_hash_q;

endmodule
